### sv/oau_pkg.sv
// ----------------------------------------------------------------------------
// oau_pkg
// Shared types, widths and constants of the octonion arithmetic unit.
// ----------------------------------------------------------------------------
package oau_pkg;

	function automatic int max_i(input int x, input int y);
		return (x > y) ? x : y;
	endfunction

	localparam int COMPONENT_WIDTH = 16;
	localparam int FRACTION_BITS   = 14;
	localparam int WORD_W          = 64;
	localparam int SCALE_W         = 16;
	localparam int TOL_W           = 16;
	localparam int LANES           = 8;
	localparam int TERMS           = 8;

	// Operand width leaves room to negate the most negative component.
	localparam int OP_W    = max_i(COMPONENT_WIDTH, SCALE_W) + 1;
	localparam int PROD_W  = 2 * OP_W;
	localparam int TERM_W  = max_i(PROD_W - FRACTION_BITS, COMPONENT_WIDTH + 1);
	localparam int SUM_W   = TERM_W + $clog2(TERMS);
	localparam int LANES_W = max_i(WORD_W, 4 * COMPONENT_WIDTH);
	localparam int CMP_W   = max_i(SUM_W, TOL_W);

	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
	typedef logic signed [OP_W-1:0]            opnd_t;
	typedef logic signed [TERM_W-1:0]          term_t;
	typedef logic signed [SUM_W-1:0]           sum_t;

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_OMUL = 3'd2,
		CMD_SMUL = 3'd3,
		CMD_CMP  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]                cmd;
		logic [WORD_W-1:0]         left_low;
		logic [WORD_W-1:0]         left_high;
		logic [WORD_W-1:0]         right_low;
		logic [WORD_W-1:0]         right_high;
		logic signed [SCALE_W-1:0] scale;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_low;
		logic [WORD_W-1:0] result_high;
		logic              equal;
		logic              saturated;
	} rsp_t;

	// Hamilton product: r[i] = sum_j +/- p[j] * q[i ^ j]; bit j of row i set
	// where that term is subtracted.
	localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

	localparam logic signed [63:0] COMP_MAX_L = (64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1;
	localparam sum_t COMP_MAX = sum_t'(COMP_MAX_L);
	localparam sum_t COMP_MIN = sum_t'(-COMP_MAX_L - 64'sd1);

endpackage

### sv/oau_products.sv
// ----------------------------------------------------------------------------
// oau_products
// Unpacks the operands and forms the eight signed terms of every result
// component: floored fixed point products for the multiplies, the raw
// components for add, subtract and compare.
// ----------------------------------------------------------------------------
module oau_products (
	input  oau_pkg::req_t                                  req,
	output oau_pkg::term_t [oau_pkg::LANES-1:0][oau_pkg::TERMS-1:0] terms,
	output logic [oau_pkg::LANES-1:0][oau_pkg::TERMS-1:0]           negs
);
	import oau_pkg::*;

	function automatic comp_t get_lane(input logic [WORD_W-1:0] w, input int n);
		logic [LANES_W-1:0] ext;
		ext = LANES_W'(w);
		return comp_t'(ext[n*COMPONENT_WIDTH +: COMPONENT_WIDTH]);
	endfunction

	function automatic opnd_t conj_at(input opnd_t x, input int k);
		return (k == 0) ? x : -x;
	endfunction

	always_comb begin
		opnd_t                 l [LANES];
		opnd_t                 r [LANES];
		opnd_t                 px [LANES][TERMS];
		opnd_t                 qx [LANES][TERMS];
		opnd_t                 s;
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] prod_sh;

		for (int n = 0; n < 4; n++) begin
			l[n]     = opnd_t'(get_lane(req.left_low, n));
			l[n + 4] = opnd_t'(get_lane(req.left_high, n));
			r[n]     = opnd_t'(get_lane(req.right_low, n));
			r[n + 4] = opnd_t'(get_lane(req.right_high, n));
		end
		s = opnd_t'(req.scale);

		for (int n = 0; n < LANES; n++) begin
			for (int k = 0; k < TERMS; k++) begin
				px[n][k] = '0;
				qx[n][k] = '0;
			end
		end
		negs = '0;

		unique case (req.cmd)
			CMD_OMUL: begin
				// (a,b)(c,d) = (ac - d conj(b), da + conj(c) b); a,c low and b,d high
				for (int i = 0; i < 4; i++) begin
					for (int j = 0; j < 4; j++) begin
						px[i][j]         = l[j];
						qx[i][j]         = r[i ^ j];
						negs[i][j]       = HAM_NEG[i][j];
						px[i][j + 4]     = r[j + 4];
						qx[i][j + 4]     = conj_at(l[(i ^ j) + 4], i ^ j);
						negs[i][j + 4]   = ~HAM_NEG[i][j];
						px[i + 4][j]     = r[j + 4];
						qx[i + 4][j]     = l[i ^ j];
						negs[i + 4][j]   = HAM_NEG[i][j];
						px[i + 4][j + 4] = conj_at(r[j], j);
						qx[i + 4][j + 4] = l[(i ^ j) + 4];
						negs[i + 4][j + 4] = HAM_NEG[i][j];
					end
				end
			end
			CMD_SMUL: begin
				for (int n = 0; n < LANES; n++) begin
					px[n][0] = l[n];
					qx[n][0] = s;
				end
			end
			default: begin
			end
		endcase

		// Arithmetic shift floors the product toward minus infinity.
		for (int n = 0; n < LANES; n++) begin
			for (int k = 0; k < TERMS; k++) begin
				prod        = px[n][k] * qx[n][k];
				prod_sh     = prod >>> FRACTION_BITS;
				terms[n][k] = term_t'(prod_sh[TERM_W-1:0]);
			end
		end

		if (req.cmd == CMD_ADD || req.cmd == CMD_SUB || req.cmd == CMD_CMP) begin
			for (int n = 0; n < LANES; n++) begin
				terms[n][0] = term_t'(l[n]);
				terms[n][1] = term_t'(r[n]);
				negs[n][1]  = (req.cmd != CMD_ADD);
			end
		end
	end

endmodule

### sv/octonion_arith_unit.sv
// ----------------------------------------------------------------------------
// octonion_arith_unit
// Fixed point octonion add, subtract, Cayley-Dickson product, scalar
// multiply and tolerance compare, pipelined over three register stages.
// ----------------------------------------------------------------------------
//  channel   handshake              payload     direction
//  req       req_valid / req_stall  req_data    in
//  rsp       rsp_valid / rsp_stall  rsp_data    out
//  cfg       cfg_we                 cfg_wdata   in (equal_tolerance)
//
// rsp_valid rises when an accepted request reaches stage three; one transaction
// enters per cycle unless stalled, set by the 64 parallel multipliers of stage one.
// Stage one forms products, stage two sums the eight terms per component,
// stage three saturates, compares and holds the response.
// Reset clears the stage valid bits and loads equal_tolerance with 1.
// A stall holds the stages behind it; empty stages still fill, so bubbles close.
// ----------------------------------------------------------------------------
module octonion_arith_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  oau_pkg::req_t               req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output oau_pkg::rsp_t               rsp_data,
	input  logic                        cfg_we,
	input  logic [oau_pkg::TOL_W-1:0]   cfg_wdata
);
	import oau_pkg::*;

	logic [TOL_W-1:0] tol_q;

	term_t [LANES-1:0][TERMS-1:0] terms;
	logic  [LANES-1:0][TERMS-1:0] negs;

	logic                         v_s1, v_s2, v_s3;
	logic [2:0]                   cmd_s1, cmd_s2;
	term_t [LANES-1:0][TERMS-1:0] terms_s1;
	logic  [LANES-1:0][TERMS-1:0] negs_s1;
	sum_t  [LANES-1:0]            sums_s2;
	rsp_t                         rsp_s3;

	logic en1, en2, en3;
	sum_t [LANES-1:0] sums;
	rsp_t             rsp_next;

	assign en3       = !v_s3 || !rsp_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = !en1;
	assign rsp_valid = v_s3;
	assign rsp_data  = rsp_s3;

	oau_products u_products (
		.req   (req_data),
		.terms (terms),
		.negs  (negs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1   <= req_data.cmd;
			terms_s1 <= terms;
			negs_s1  <= negs;
		end
		if (en2) begin
			cmd_s2  <= cmd_s1;
			sums_s2 <= sums;
		end
		if (en3) begin
			rsp_s3 <= rsp_next;
		end
	end

	// Stage two: exact sum of the signed terms of each component.
	always_comb begin
		sum_t acc;
		sum_t t;
		for (int n = 0; n < LANES; n++) begin
			acc = '0;
			for (int k = 0; k < TERMS; k++) begin
				t   = sum_t'(terms_s1[n][k]);
				acc = negs_s1[n][k] ? acc - t : acc + t;
			end
			sums[n] = acc;
		end
	end

	// Stage three: saturate and pack, or compare against the tolerance.
	always_comb begin
		logic [LANES_W-1:0] lo_ext;
		logic [LANES_W-1:0] hi_ext;
		logic               sat;
		logic               eq;
		sum_t               v;
		sum_t               mag;
		comp_t              c;

		lo_ext = '0;
		hi_ext = '0;
		sat    = 1'b0;
		eq     = 1'b1;
		for (int n = 0; n < LANES; n++) begin
			v = sums_s2[n];
			if (v > COMP_MAX) begin
				c   = comp_t'(COMP_MAX);
				sat = 1'b1;
			end else if (v < COMP_MIN) begin
				c   = comp_t'(COMP_MIN);
				sat = 1'b1;
			end else begin
				c = comp_t'(v);
			end
			if (n < 4) lo_ext[n*COMPONENT_WIDTH +: COMPONENT_WIDTH] = c;
			else       hi_ext[(n-4)*COMPONENT_WIDTH +: COMPONENT_WIDTH] = c;

			mag = (v < 0) ? -v : v;
			if (CMP_W'(unsigned'(mag)) >= CMP_W'(tol_q)) eq = 1'b0;
		end

		rsp_next = '0;
		unique case (cmd_s2)
			CMD_ADD, CMD_SUB, CMD_OMUL, CMD_SMUL: begin
				rsp_next.result_low  = lo_ext[WORD_W-1:0];
				rsp_next.result_high = hi_ext[WORD_W-1:0];
				rsp_next.saturated   = sat;
			end
			CMD_CMP: begin
				rsp_next.equal = eq;
			end
			default: begin
			end
		endcase
	end

endmodule

### test/tb_octonion_arith_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_octonion_arith_unit
// Drives add, subtract, octonion and scalar product, compare and reserved
// code transactions through the unit under random valid gaps and response
// stalls. A fixed point model in this bench predicts each response. The
// checker matches every response in order against the predictions.
// ----------------------------------------------------------------------------
module tb_octonion_arith_unit;
	import oau_pkg::*;

	localparam int CW           = COMPONENT_WIDTH;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int REPORT_MAX   = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req_data;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp_data;
	logic                  cfg_we;
	logic [TOL_W-1:0]      cfg_wdata;

	rsp_t                  pending_results[$];
	logic [TOL_W-1:0]      tolerance;
	int                    send_gap_pct;
	int                    stall_pct;
	int                    mismatch_count;
	int                    checked_count;
	int                    tolerance_writes;
	int                    cycle_count;
	int                    sent_by_cmd[8];

	octonion_arith_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Fixed point prediction
	// ------------------------------------------------------------------
	function automatic longint component_of(input logic [WORD_W-1:0] w, input int n);
		return longint'($signed(w[n*CW +: CW]));
	endfunction

	// Product rounded toward minus infinity.
	function automatic longint fx_mul(input longint x, input longint y);
		return (x * y) >>> FRACTION_BITS;
	endfunction

	function automatic logic [CW-1:0] clip_component(input longint v, inout bit sat);
		longint top;
		longint bot;
		top = (longint'(1) <<< (CW - 1)) - 1;
		bot = -top - 1;
		if (v > top) begin
			v = top;
			sat = 1'b1;
		end
		if (v < bot) begin
			v = bot;
			sat = 1'b1;
		end
		return v[CW-1:0];
	endfunction

	// acc +/-= p * q over Hamilton quaternions; conjugate operands before the
	// products, since floor rounding makes negation after the fact differ.
	function automatic void hamilton_acc(inout longint acc[4], input longint p[4],
			input longint q[4], input bit conj_p, input bit conj_q, input bit negate);
		longint pa, pb, pc, pd, qa, qb, qc, qd;
		longint part[4];
		pa = p[0]; pb = p[1]; pc = p[2]; pd = p[3];
		qa = q[0]; qb = q[1]; qc = q[2]; qd = q[3];
		if (conj_p) begin
			pb = -pb; pc = -pc; pd = -pd;
		end
		if (conj_q) begin
			qb = -qb; qc = -qc; qd = -qd;
		end
		part[0] = fx_mul(pa, qa) - fx_mul(pb, qb) - fx_mul(pc, qc) - fx_mul(pd, qd);
		part[1] = fx_mul(pa, qb) + fx_mul(pb, qa) + fx_mul(pc, qd) - fx_mul(pd, qc);
		part[2] = fx_mul(pa, qc) - fx_mul(pb, qd) + fx_mul(pc, qa) + fx_mul(pd, qb);
		part[3] = fx_mul(pa, qd) + fx_mul(pb, qc) - fx_mul(pc, qb) + fx_mul(pd, qa);
		for (int n = 0; n < 4; n++)
			acc[n] = negate ? acc[n] - part[n] : acc[n] + part[n];
	endfunction

	function automatic rsp_t predict_result(input req_t item, input logic [TOL_W-1:0] tol);
		longint lhs[8];
		longint rhs[8];
		longint res[8];
		longint l_a[4], l_b[4], r_c[4], r_d[4], acc_lo[4], acc_hi[4];
		longint s;
		longint diff;
		bit     sat;
		rsp_t   r;
		r   = '0;
		sat = 1'b0;
		s   = longint'(item.scale);
		for (int n = 0; n < 4; n++) begin
			lhs[n]     = component_of(item.left_low, n);
			lhs[n + 4] = component_of(item.left_high, n);
			rhs[n]     = component_of(item.right_low, n);
			rhs[n + 4] = component_of(item.right_high, n);
			l_a[n] = lhs[n]; l_b[n] = lhs[n + 4];
			r_c[n] = rhs[n]; r_d[n] = rhs[n + 4];
			acc_lo[n] = 0; acc_hi[n] = 0;
		end
		for (int n = 0; n < 8; n++)
			res[n] = 0;
		case (item.cmd)
			CMD_ADD: begin
				for (int n = 0; n < 8; n++)
					res[n] = lhs[n] + rhs[n];
			end
			CMD_SUB: begin
				for (int n = 0; n < 8; n++)
					res[n] = lhs[n] - rhs[n];
			end
			CMD_OMUL: begin
				// (a,b)(c,d) = (ac - d conj(b), da + conj(c) b)
				hamilton_acc(acc_lo, l_a, r_c, 1'b0, 1'b0, 1'b0);
				hamilton_acc(acc_lo, r_d, l_b, 1'b0, 1'b1, 1'b1);
				hamilton_acc(acc_hi, r_d, l_a, 1'b0, 1'b0, 1'b0);
				hamilton_acc(acc_hi, r_c, l_b, 1'b1, 1'b0, 1'b0);
				for (int n = 0; n < 4; n++) begin
					res[n]     = acc_lo[n];
					res[n + 4] = acc_hi[n];
				end
			end
			CMD_SMUL: begin
				for (int n = 0; n < 8; n++)
					res[n] = fx_mul(lhs[n], s);
			end
			CMD_CMP: begin
				r.equal = 1'b1;
				for (int n = 0; n < 8; n++) begin
					diff = lhs[n] - rhs[n];
					if (diff < 0)
						diff = -diff;
					if (diff >= longint'(tol))
						r.equal = 1'b0;
				end
			end
			default: ;
		endcase
		if (item.cmd <= CMD_SMUL) begin
			for (int n = 0; n < 4; n++) begin
				r.result_low[n*CW +: CW]  = clip_component(res[n], sat);
				r.result_high[n*CW +: CW] = clip_component(res[n + 4], sat);
			end
			r.saturated = sat;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [WORD_W-1:0] splat(input logic [CW-1:0] v);
		return {4{v}};
	endfunction

	function automatic logic [CW-1:0] pick_component();
		case ($urandom_range(0, 5))
			0, 1, 2: return CW'($urandom);
			3: begin
				case ($urandom_range(0, 5))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hFFFF;
					4: return 16'h4000;
					default: return 16'hC000;
				endcase
			end
			4: return CW'(int'($urandom_range(0, 512)) - 256);
			default: return CW'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		for (int n = 0; n < 4; n++)
			w[n*CW +: CW] = pick_component();
		return w;
	endfunction

	// Move each component by at most span, so compares land near the threshold.
	function automatic logic [WORD_W-1:0] nudge_word(input logic [WORD_W-1:0] w,
			input int span);
		logic [WORD_W-1:0] out;
		for (int n = 0; n < 4; n++)
			out[n*CW +: CW] = w[n*CW +: CW]
				+ CW'(int'($urandom_range(0, 2 * span)) - span);
		return out;
	endfunction

	function automatic req_t make_req(input logic [2:0] cmd, input logic [WORD_W-1:0] ll,
			input logic [WORD_W-1:0] lh, input logic [WORD_W-1:0] rl,
			input logic [WORD_W-1:0] rh, input logic [SCALE_W-1:0] scale);
		req_t item;
		item.cmd        = cmd;
		item.left_low   = ll;
		item.left_high  = lh;
		item.right_low  = rl;
		item.right_high = rh;
		item.scale      = scale;
		return item;
	endfunction

	function automatic req_t random_req(input int span);
		req_t item;
		int   pick;
		pick = $urandom_range(0, 20);
		item = make_req(3'(pick / 4), pick_word(), pick_word(), pick_word(), pick_word(),
			SCALE_W'($urandom));
		if (pick == 20)
			item.cmd = 3'(CMD_CMP + 1 + $urandom_range(0, 2));
		else if ($urandom_range(0, 3) == 0)
			item.scale = pick_component();
		if (item.cmd == CMD_CMP && $urandom_range(0, 9) < 7) begin
			item.right_low  = nudge_word(item.left_low, span);
			item.right_high = nudge_word(item.left_high, span);
		end
		return item;
	endfunction

	// Hold the payload until accepted; valid stays high into the next call.
	task automatic send_op(input req_t item);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(predict_result(item, tolerance));
		sent_by_cmd[item.cmd]++;
	endtask

	task automatic drain_pipe();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_W-1:0] value);
		drain_pipe();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tolerance = value;
		tolerance_writes++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [WORD_W-1:0] w0, w1;
		w0 = pick_word();
		w1 = pick_word();
		send_op(make_req(CMD_ADD, '0, '0, '0, '0, '0));
		send_op(make_req(CMD_ADD, splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF),
			splat(16'h7FFF), '0));
		send_op(make_req(CMD_ADD, splat(16'h8000), splat(16'h8000), splat(16'h8000),
			splat(16'h8000), '0));
		send_op(make_req(CMD_SUB, splat(16'h8000), splat(16'h8000), splat(16'h7FFF),
			splat(16'h7FFF), '0));
		send_op(make_req(CMD_SUB, splat(16'h7FFF), splat(16'h7FFF), splat(16'h8000),
			splat(16'h8000), '0));
		send_op(make_req(CMD_SUB, splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF),
			splat(16'h7FFF), '0));
		// real unit on the left: product returns the right operand
		send_op(make_req(CMD_OMUL, 64'h4000, '0, w0, w1, '0));
		send_op(make_req(CMD_OMUL, splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF),
			splat(16'h7FFF), '0));
		send_op(make_req(CMD_OMUL, splat(16'h8000), splat(16'h8000), splat(16'h8000),
			splat(16'h8000), '0));
		// fourth basis unit squared gives minus one
		send_op(make_req(CMD_OMUL, '0, 64'h4000, '0, 64'h4000, '0));
		send_op(make_req(CMD_OMUL, w1, w0, w0, w1, '0));
		send_op(make_req(CMD_SMUL, splat(16'h8000), splat(16'h8000), w0, w1, 16'h8000));
		send_op(make_req(CMD_SMUL, splat(16'h7FFF), splat(16'h7FFF), w0, w1, 16'h7FFF));
		send_op(make_req(CMD_SMUL, w0, w1, '0, '0, 16'h4000));
		// smallest positive times minus one rounds down to minus one
		send_op(make_req(CMD_SMUL, splat(16'h0001), splat(16'h0001), '0, '0, 16'hFFFF));
		send_op(make_req(CMD_SMUL, w0, w1, '0, '0, '0));
		send_op(make_req(CMD_CMP, w0, w1, w0, w1, '0));
		send_op(make_req(CMD_CMP, w0, w1, w0 ^ 64'h1, w1, '0));
		send_op(make_req(CMD_CMP, w0, w1, w1, w0, '0));
		for (int c = CMD_CMP + 1; c < 8; c++)
			send_op(make_req(3'(c), w0, w1, w1, w0, SCALE_W'($urandom)));
	endtask

	task automatic test_tolerance_edges();
		logic [WORD_W-1:0] w0;
		w0 = pick_word();
		// zero tolerance: even identical operands compare unequal
		set_tolerance('0);
		send_op(make_req(CMD_CMP, w0, w0, w0, w0, '0));
		set_tolerance('1);
		send_op(make_req(CMD_CMP, splat(16'h7FFF), splat(16'h7FFF), splat(16'h8000),
			splat(16'h8000), '0));
		send_op(make_req(CMD_CMP, splat(16'h7FFF), splat(16'h7FFF), splat(16'h8001),
			splat(16'h8001), '0));
		send_op(make_req(CMD_CMP, splat(16'h8000), '0, splat(16'h7FFF), '0, '0));
		set_tolerance(TOL_W'(2));
		send_op(make_req(CMD_CMP, splat(16'h0005), splat(16'h0005), splat(16'h0004),
			splat(16'h0006), '0));
		send_op(make_req(CMD_CMP, splat(16'h0005), splat(16'h0005), splat(16'h0003),
			splat(16'h0005), '0));
	endtask

	task automatic test_random(input int count, input int gap, input int stall,
			input logic [TOL_W-1:0] tol);
		int span;
		set_tolerance(tol);
		send_gap_pct = gap;
		stall_pct    = stall;
		span = (int'(tol) < 1024) ? int'(tol) : 1024;
		for (int i = 0; i < count; i++)
			send_op(random_req(span));
	endtask

	// ------------------------------------------------------------------
	// Response stall and checker
	// ------------------------------------------------------------------
	always @(posedge clk)
		rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	task automatic report_mismatch(input string why, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t %s: expected lo=%h hi=%h eq=%b sat=%b, got lo=%h hi=%h eq=%b sat=%b",
				$realtime, why, want.result_low, want.result_high, want.equal,
				want.saturated, got.result_low, got.result_high, got.equal, got.saturated);
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", '0, rsp_data);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (rsp_data.result_low !== want.result_low
						|| rsp_data.result_high !== want.result_high
						|| rsp_data.equal !== want.equal
						|| rsp_data.saturated !== want.saturated)
					report_mismatch("response mismatch", want, rsp_data);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
			pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		req_valid        <= 1'b0;
		req_data         <= '0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		tolerance        = TOL_W'(1);
		send_gap_pct     = 0;
		stall_pct        = 0;
		mismatch_count   = 0;
		checked_count    = 0;
		tolerance_writes = 0;
		for (int c = 0; c < 8; c++)
			sent_by_cmd[c] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tolerance_edges();
		test_random(450, 26, 50, TOL_W'($urandom_range(1, 300)));
		test_random(450, 50, 26, TOL_W'($urandom));
		test_random(450, 0, 0, TOL_W'(16));
		drain_pipe();

		$display("checked %0d transactions: add %0d, sub %0d, omul %0d, smul %0d, cmp %0d,",
			checked_count, sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_SUB], sent_by_cmd[CMD_OMUL],
			sent_by_cmd[CMD_SMUL], sent_by_cmd[CMD_CMP]);
		$display("reserved codes %0d, tolerance writes %0d, mismatches %0d",
			sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7], tolerance_writes,
			mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
sv/oau_pkg.sv
sv/oau_products.sv
sv/octonion_arith_unit.sv
test/tb_octonion_arith_unit.sv
